// File: hdl/spd_pkg.sv
// spd_pkg: shared types, constants and codes for the shortest path distance unit
// used by spd_ctrl, spd_datapath and shortest_path_distance_unit
`timescale 1ns / 1ps

package spd_pkg;

  localparam int MAX_NODES     = 1024;
  localparam int MAX_EDGES     = 4096;
  localparam int HEAP_DEPTH    = MAX_EDGES + 1;
  localparam int NODE_BITS     = $clog2(MAX_NODES);
  localparam int NCNT_BITS     = NODE_BITS + 1;
  localparam int EDGE_IDX_BITS = $clog2(MAX_EDGES);
  localparam int FILL_BITS     = $clog2(HEAP_DEPTH + 1);
  localparam int HEAP_IDX_BITS = $clog2(HEAP_DEPTH);
  localparam int WEIGHT_BITS   = 16;
  localparam int DIST_BITS     = 32;

  localparam logic [1:0] FUNC_ADD   = 2'd0;
  localparam logic [1:0] FUNC_QUERY = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_FULL        = 2'd1;
  localparam logic [1:0] ST_UNREACHABLE = 2'd2;
  localparam logic [1:0] ST_RANGE       = 2'd3;

  typedef struct packed {
    logic [1:0]  func;
    logic [9:0]  node_a;
    logic [9:0]  node_b;
    logic [15:0] edge_weight;
  } spd_in_t;

  typedef struct packed {
    logic [31:0] path_distance;
    logic [1:0]  status;
  } spd_out_t;

  typedef struct packed {
    logic [NODE_BITS-1:0]   from_node;
    logic [NODE_BITS-1:0]   to_node;
    logic [WEIGHT_BITS-1:0] weight;
  } edge_t;

  typedef struct packed {
    logic [DIST_BITS-1:0] key;
    logic [NODE_BITS-1:0] node;
  } heap_ent_t;

  typedef struct packed {
    logic                 reached;
    logic [DIST_BITS-1:0] cost;
  } dist_ent_t;

  typedef struct packed {
    logic       latch;
    logic       add_edge;
    logic       clr_edges;
    logic       set_res;
    logic [1:0] res_status;
    logic       res_use_dist;
    logic       clr_start;
    logic       clr_step;
    logic       seed;
    logic       pop_rd_top;
    logic       pop_take;
    logic       sd_start;
    logic       sd_rd_l;
    logic       sd_rd_r;
    logic       sd_cmp;
    logic       rlx_start;
    logic       du_take;
    logic       e_rd;
    logic       e_chk;
    logic       e_upd;
    logic       su_rd;
    logic       su_cmp;
    logic       fin_rd;
    logic       load_out;
  } spd_cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       range_bad;
    logic       a_eq_b;
    logic       edge_full;
    logic       clr_last;
    logic       heap_empty;
    logic       sd_l_out;
    logic       sd_move;
    logic       edge_done;
    logic       edge_match;
    logic       push_ok;
    logic       su_root;
    logic       su_stop;
    logic       target_reached;
    logic       out_free;
  } spd_stat_t;

endpackage

// File: hdl/spd_ctrl.sv
// spd_ctrl: sequencer for item decode, distance clear, heap pop/push and edge scan
// depends on spd_pkg; drives spd_datapath through command/status structs
`timescale 1ns / 1ps

module spd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  spd_pkg::spd_stat_t stat_i,
  output spd_pkg::spd_cmd_t  cmd_o
);
  import spd_pkg::*;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_DEC   = 5'd1;
  localparam logic [4:0] S_CLR   = 5'd2;
  localparam logic [4:0] S_SEED  = 5'd3;
  localparam logic [4:0] S_POP0  = 5'd4;
  localparam logic [4:0] S_POP1  = 5'd5;
  localparam logic [4:0] S_POP2  = 5'd6;
  localparam logic [4:0] S_SD_L  = 5'd7;
  localparam logic [4:0] S_SD_R  = 5'd8;
  localparam logic [4:0] S_SD_C  = 5'd9;
  localparam logic [4:0] S_RLX   = 5'd10;
  localparam logic [4:0] S_DU    = 5'd11;
  localparam logic [4:0] S_E0    = 5'd12;
  localparam logic [4:0] S_E1    = 5'd13;
  localparam logic [4:0] S_E2    = 5'd14;
  localparam logic [4:0] S_SU0   = 5'd15;
  localparam logic [4:0] S_SU1   = 5'd16;
  localparam logic [4:0] S_FIN   = 5'd17;
  localparam logic [4:0] S_FIN2  = 5'd18;
  localparam logic [4:0] S_DONE  = 5'd19;

  logic [4:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DEC;
        end
      end
      S_DEC: begin
        cmd_o.set_res = 1'b1;
        state_d       = S_DONE;
        case (stat_i.func)
          FUNC_ADD: begin
            if (stat_i.range_bad) begin
              cmd_o.res_status = ST_RANGE;
            end else if (stat_i.edge_full) begin
              cmd_o.res_status = ST_FULL;
            end else begin
              cmd_o.add_edge = 1'b1;
            end
          end
          FUNC_QUERY: begin
            if (stat_i.range_bad) begin
              cmd_o.res_status = ST_RANGE;
            end else if (!stat_i.a_eq_b) begin
              cmd_o.set_res   = 1'b0;
              cmd_o.clr_start = 1'b1;
              state_d         = S_CLR;
            end
          end
          FUNC_CLEAR: cmd_o.clr_edges = 1'b1;
          default: ;
        endcase
      end
      S_CLR: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_last) state_d = S_SEED;
      end
      S_SEED: begin
        cmd_o.seed = 1'b1;
        state_d    = S_POP0;
      end
      S_POP0: begin
        if (stat_i.heap_empty) begin
          state_d = S_FIN;
        end else begin
          cmd_o.pop_rd_top = 1'b1;
          state_d          = S_POP1;
        end
      end
      S_POP1: begin
        cmd_o.pop_take = 1'b1;
        state_d        = S_POP2;
      end
      S_POP2: begin
        cmd_o.sd_start = 1'b1;
        state_d        = S_SD_L;
      end
      S_SD_L: begin
        cmd_o.sd_rd_l = 1'b1;
        state_d       = stat_i.sd_l_out ? S_RLX : S_SD_R;
      end
      S_SD_R: begin
        cmd_o.sd_rd_r = 1'b1;
        state_d       = S_SD_C;
      end
      S_SD_C: begin
        cmd_o.sd_cmp = 1'b1;
        state_d      = stat_i.sd_move ? S_SD_L : S_RLX;
      end
      S_RLX: begin
        cmd_o.rlx_start = 1'b1;
        state_d         = S_DU;
      end
      S_DU: begin
        cmd_o.du_take = 1'b1;
        state_d       = S_E0;
      end
      S_E0: begin
        if (stat_i.edge_done) begin
          state_d = S_POP0;
        end else begin
          cmd_o.e_rd = 1'b1;
          state_d    = S_E1;
        end
      end
      S_E1: begin
        cmd_o.e_chk = 1'b1;
        state_d     = stat_i.edge_match ? S_E2 : S_E0;
      end
      S_E2: begin
        cmd_o.e_upd = 1'b1;
        state_d     = stat_i.push_ok ? S_SU0 : S_E0;
      end
      S_SU0: begin
        cmd_o.su_rd = 1'b1;
        state_d     = stat_i.su_root ? S_E0 : S_SU1;
      end
      S_SU1: begin
        cmd_o.su_cmp = 1'b1;
        state_d      = stat_i.su_stop ? S_E0 : S_SU0;
      end
      S_FIN: begin
        cmd_o.fin_rd = 1'b1;
        state_d      = S_FIN2;
      end
      S_FIN2: begin
        cmd_o.set_res      = 1'b1;
        cmd_o.res_use_dist = stat_i.target_reached;
        cmd_o.res_status   = stat_i.target_reached ? ST_OK : ST_UNREACHABLE;
        state_d            = S_DONE;
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// File: hdl/spd_datapath.sv
// spd_datapath: edge store, distance store, frontier heap, counters and result register
// depends on spd_pkg; sequenced by spd_ctrl
`timescale 1ns / 1ps

module spd_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  spd_pkg::spd_in_t      in_data_i,
  input  logic                  cfg_we_i,
  input  logic [10:0]           cfg_data_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output spd_pkg::spd_out_t     out_data_o,
  input  spd_pkg::spd_cmd_t     cmd_i,
  output spd_pkg::spd_stat_t    stat_o
);
  import spd_pkg::*;

  edge_t     edge_mem [MAX_EDGES];
  dist_ent_t dist_mem [MAX_NODES];
  heap_ent_t heap_mem [HEAP_DEPTH];

  logic [NCNT_BITS-1:0]     node_count_q;
  logic [EDGE_IDX_BITS:0]   edge_fill_q;
  logic [FILL_BITS-1:0]     heap_fill_q;
  logic                     out_valid_q;
  spd_out_t                 out_q;
  spd_in_t                  item_q;
  logic [DIST_BITS-1:0]     res_dist_q;
  logic [1:0]               res_status_q;
  logic [NODE_BITS-1:0]     clr_cnt_q;
  logic [NODE_BITS-1:0]     u_q, v_q;
  logic [DIST_BITS-1:0]     du_q, nd_q;
  heap_ent_t                cur_q, lv_q;
  logic [HEAP_IDX_BITS-1:0] i_q;
  logic [EDGE_IDX_BITS:0]   j_q;
  edge_t                    ed_q;
  dist_ent_t                dm_q;
  heap_ent_t                hm_q;

  logic [NCNT_BITS-1:0]     nc;
  logic [HEAP_IDX_BITS:0]   l_idx, r_idx;
  logic [HEAP_IDX_BITS-1:0] p_idx;
  logic                     r_in, take_l, take_r, better;
  heap_ent_t                best, child;
  logic [DIST_BITS:0]       sum;
  logic [DIST_BITS-1:0]     nd;

  // heap port
  logic                     h_we, h_re;
  logic [HEAP_IDX_BITS-1:0] h_addr;
  heap_ent_t                h_wdata;
  // distance port
  logic                     d_we, d_re;
  logic [NODE_BITS-1:0]     d_addr;
  dist_ent_t                d_wdata;

  assign nc = (node_count_q > NCNT_BITS'(MAX_NODES)) ? NCNT_BITS'(MAX_NODES) : node_count_q;

  assign l_idx = {i_q, 1'b1};
  assign r_idx = l_idx + 1'b1;
  assign p_idx = (i_q - 1'b1) >> 1;
  assign r_in  = r_idx < {1'b0, heap_fill_q};

  assign take_l = lv_q.key < cur_q.key;
  assign best   = take_l ? lv_q : cur_q;
  assign take_r = r_in && (hm_q.key < best.key);
  assign child  = take_r ? hm_q : lv_q;

  assign sum    = {1'b0, du_q} + (DIST_BITS + 1)'(ed_q.weight);
  assign nd     = sum[DIST_BITS] ? {DIST_BITS{1'b1}} : sum[DIST_BITS-1:0];
  assign better = !dm_q.reached || (dm_q.cost > nd_q);

  always_comb begin
    stat_o.func           = item_q.func;
    stat_o.range_bad      = ({1'b0, item_q.node_a} >= nc) || ({1'b0, item_q.node_b} >= nc);
    stat_o.a_eq_b         = item_q.node_a == item_q.node_b;
    stat_o.edge_full      = edge_fill_q == (EDGE_IDX_BITS + 1)'(MAX_EDGES);
    stat_o.clr_last       = clr_cnt_q == NODE_BITS'(MAX_NODES - 1);
    stat_o.heap_empty     = heap_fill_q == '0;
    stat_o.sd_l_out       = l_idx >= {1'b0, heap_fill_q};
    stat_o.sd_move        = take_l || take_r;
    stat_o.edge_done      = j_q >= edge_fill_q;
    stat_o.edge_match     = (ed_q.from_node == u_q) && ({1'b0, ed_q.from_node} < nc)
                            && ({1'b0, ed_q.to_node} < nc);
    stat_o.push_ok        = better && (heap_fill_q != FILL_BITS'(HEAP_DEPTH));
    stat_o.su_root        = i_q == '0;
    stat_o.su_stop        = hm_q.key <= cur_q.key;
    stat_o.target_reached = dm_q.reached;
    stat_o.out_free       = !out_valid_q || out_ready_i;
  end

  always_comb begin
    h_we    = 1'b0;
    h_re    = 1'b0;
    h_addr  = '0;
    h_wdata = cur_q;
    if (cmd_i.seed) begin
      h_we    = 1'b1;
      h_wdata = '{key: '0, node: item_q.node_a};
    end else if (cmd_i.pop_rd_top) begin
      h_re = 1'b1;
    end else if (cmd_i.pop_take) begin
      h_re   = 1'b1;
      h_addr = HEAP_IDX_BITS'(heap_fill_q - 1'b1);
    end else if (cmd_i.sd_rd_l) begin
      if (stat_o.sd_l_out) begin
        h_we   = 1'b1;
        h_addr = i_q;
      end else begin
        h_re   = 1'b1;
        h_addr = l_idx[HEAP_IDX_BITS-1:0];
      end
    end else if (cmd_i.sd_rd_r) begin
      h_re   = r_in;
      h_addr = r_idx[HEAP_IDX_BITS-1:0];
    end else if (cmd_i.sd_cmp) begin
      h_we    = 1'b1;
      h_addr  = i_q;
      h_wdata = stat_o.sd_move ? child : cur_q;
    end else if (cmd_i.su_rd) begin
      if (stat_o.su_root) begin
        h_we = 1'b1;
      end else begin
        h_re   = 1'b1;
        h_addr = p_idx;
      end
    end else if (cmd_i.su_cmp) begin
      h_we    = 1'b1;
      h_addr  = i_q;
      h_wdata = stat_o.su_stop ? cur_q : hm_q;
    end
  end

  always_comb begin
    d_we    = 1'b0;
    d_re    = 1'b0;
    d_addr  = '0;
    d_wdata = '{reached: 1'b0, cost: '0};
    if (cmd_i.clr_step) begin
      d_we   = 1'b1;
      d_addr = clr_cnt_q;
    end else if (cmd_i.seed) begin
      d_we    = 1'b1;
      d_addr  = item_q.node_a;
      d_wdata = '{reached: 1'b1, cost: '0};
    end else if (cmd_i.rlx_start) begin
      d_re   = 1'b1;
      d_addr = u_q;
    end else if (cmd_i.e_chk) begin
      d_re   = 1'b1;
      d_addr = ed_q.to_node;
    end else if (cmd_i.e_upd) begin
      d_we    = better;
      d_addr  = v_q;
      d_wdata = '{reached: 1'b1, cost: nd_q};
    end else if (cmd_i.fin_rd) begin
      d_re   = 1'b1;
      d_addr = item_q.node_b;
    end
  end

  always_ff @(posedge clk_i) begin
    if (h_we) heap_mem[h_addr] <= h_wdata;
    if (h_re) hm_q <= heap_mem[h_addr];
  end

  always_ff @(posedge clk_i) begin
    if (d_we) dist_mem[d_addr] <= d_wdata;
    if (d_re) dm_q <= dist_mem[d_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.add_edge) begin
      edge_mem[edge_fill_q[EDGE_IDX_BITS-1:0]] <= '{from_node: item_q.node_a,
                                                   to_node: item_q.node_b,
                                                   weight: item_q.edge_weight};
    end
    if (cmd_i.e_rd) ed_q <= edge_mem[j_q[EDGE_IDX_BITS-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= NCNT_BITS'(MAX_NODES);
      edge_fill_q  <= '0;
      heap_fill_q  <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) node_count_q <= cfg_data_i;
      if (cmd_i.add_edge) edge_fill_q <= edge_fill_q + 1'b1;
      if (cmd_i.clr_edges) edge_fill_q <= '0;
      if (cmd_i.seed) heap_fill_q <= FILL_BITS'(1);
      if (cmd_i.pop_take) heap_fill_q <= heap_fill_q - 1'b1;
      if (cmd_i.e_upd && stat_o.push_ok) heap_fill_q <= heap_fill_q + 1'b1;
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) item_q <= in_data_i;
    if (cmd_i.set_res) begin
      res_status_q <= cmd_i.res_status;
      res_dist_q   <= cmd_i.res_use_dist ? dm_q.cost : '0;
    end
    if (cmd_i.clr_start) clr_cnt_q <= '0;
    if (cmd_i.clr_step) clr_cnt_q <= clr_cnt_q + 1'b1;
    if (cmd_i.pop_take) u_q <= hm_q.node;
    if (cmd_i.sd_start) begin
      cur_q <= hm_q;
      i_q   <= '0;
    end
    if (cmd_i.sd_rd_r) lv_q <= hm_q;
    if (cmd_i.sd_cmp && stat_o.sd_move) begin
      i_q <= take_r ? r_idx[HEAP_IDX_BITS-1:0] : l_idx[HEAP_IDX_BITS-1:0];
    end
    if (cmd_i.rlx_start) j_q <= '0;
    if (cmd_i.du_take) du_q <= dm_q.cost;
    if (cmd_i.e_chk) begin
      j_q  <= j_q + 1'b1;
      nd_q <= nd;
      v_q  <= ed_q.to_node;
    end
    if (cmd_i.e_upd && stat_o.push_ok) begin
      i_q   <= heap_fill_q[HEAP_IDX_BITS-1:0];
      cur_q <= '{key: nd_q, node: v_q};
    end
    if (cmd_i.su_cmp && !stat_o.su_stop) i_q <= p_idx;
    if (cmd_i.load_out) out_q <= '{path_distance: res_dist_q, status: res_status_q};
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: hdl/shortest_path_distance_unit.sv
// shortest_path_distance_unit: add, clear and same-node query are decoded and answered directly;
// a query clears the 1024-entry distance store, then per pop sifts the heap down level by level,
// scans every stored edge, relaxes each matching edge and climbs the heap level by level on its push.
// One item is worked on at a time; the next input can be taken in the cycle after the result
// is loaded. Reset (async, active low) empties the edge store and heap and sets node_count to 1024.
// depends on spd_pkg, spd_ctrl, spd_datapath
`timescale 1ns / 1ps

module shortest_path_distance_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  spd_pkg::spd_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output spd_pkg::spd_out_t out_data_o,
  input  logic              cfg_we_i,
  input  logic [10:0]       cfg_data_i
);
  import spd_pkg::*;

  spd_cmd_t  cmd;
  spd_stat_t stat;

  spd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  spd_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule
